FILE: rtl/core/ascm_pkg.sv
// ----------------------------------------------------------------------------
// ascm_pkg
// Widths, range table and record types shared by the size class mapper.
// ----------------------------------------------------------------------------
package ascm_pkg;

	localparam int unsigned SizeW     = 18;   // request_size field
	localparam int unsigned EffW      = 19;   // size with the probe bit on top
	localparam int unsigned ClsW      = 8;
	localparam int unsigned RndW      = 19;   // rounded_size field
	localparam int unsigned RndFullW  = 20;   // rounded size before masking
	localparam int unsigned BatchW    = 10;
	localparam int unsigned QuoW      = 10;   // quotient bits resolved by the divider row
	localparam int unsigned TrialW    = RndFullW + QuoW - 1;
	localparam int unsigned MaxW      = 21;   // holds the largest legal maximum
	localparam int unsigned NumRanges = 5;

	localparam int unsigned DefMaxRequestBytes = 262144;
	localparam int unsigned BatchBudget        = 256 * 1024;
	localparam int unsigned BatchMin           = 2;
	localparam int unsigned BatchMax           = 526;
	// largest rounded size whose quotient still exceeds BatchMax
	localparam int unsigned SatRnd             = BatchBudget / (BatchMax + 1);

	typedef struct packed {
		logic [EffW-1:0]     sz;
		logic                hit;
		logic [ClsW-1:0]     cls;
		logic [RndFullW-1:0] rnd;
		logic                too_large;
	} class_rec_t;

	typedef struct packed {
		logic [ClsW-1:0]     cls;
		logic [RndFullW-1:0] rnd;
		logic                too_large;
		logic                sat;
		logic [EffW-1:0]     rem;
		logic [QuoW-1:0]     quo;
	} div_rec_t;

	// piecewise range table: first class, lower bound, granule shift, upper bound
	function automatic int unsigned range_base(input int unsigned idx);
		unique case (idx)
			0: return 0;
			1: return 16;
			2: return 72;
			3: return 128;
			4: return 184;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned range_lo(input int unsigned idx);
		unique case (idx)
			0: return 0;
			1: return 128;
			2: return 1024;
			3: return 8 * 1024;
			4: return 64 * 1024;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned range_shift(input int unsigned idx);
		unique case (idx)
			0: return 3;
			1: return 4;
			2: return 7;
			3: return 10;
			4: return 13;
			default: return 3;
		endcase
	endfunction

	// top range takes everything that is left
	function automatic int unsigned range_hi(input int unsigned idx);
		unique case (idx)
			0: return 128;
			1: return 1024;
			2: return 8 * 1024;
			3: return 64 * 1024;
			4: return (1 << RndFullW) - 1;
			default: return 0;
		endcase
	endfunction

endpackage

FILE: rtl/core/ascm_if.sv
// ----------------------------------------------------------------------------
// ascm request / response channels
// Valid/ready channels carrying a size lookup request and its result.
// ----------------------------------------------------------------------------
interface ascm_req_if import ascm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SizeW-1:0] request_size;
	logic             oversize_probe;

	modport source (output valid, output request_size, output oversize_probe, input ready);
	modport sink   (input valid, input request_size, input oversize_probe, output ready);
endinterface

interface ascm_rsp_if import ascm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ClsW-1:0]   class_index;
	logic [RndW-1:0]   rounded_size;
	logic [BatchW-1:0] batch_count;
	logic              too_large;

	modport source (output valid, output class_index, output rounded_size,
		output batch_count, output too_large, input ready);
	modport sink   (input valid, input class_index, input rounded_size,
		input batch_count, input too_large, output ready);
endinterface

FILE: rtl/core/ascm_class_cell.sv
// ----------------------------------------------------------------------------
// ascm_class_cell
// One size range: claims a size not yet claimed upstream that falls at or
// below its upper bound and works out class index and rounded size.
// ----------------------------------------------------------------------------
module ascm_class_cell import ascm_pkg::*; #(
	parameter int unsigned BASE  = 0,
	parameter int unsigned LO    = 0,
	parameter int unsigned SHIFT = 3,
	parameter int unsigned HI    = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  class_rec_t in_rec,
	output logic       out_valid,
	output class_rec_t out_rec
);

	logic                valid_q;
	class_rec_t          rec_q;
	class_rec_t          rec_d;
	logic [RndFullW-1:0] sz_ext;
	logic [RndFullW-1:0] off;
	logic [RndFullW-1:0] units;
	logic                match;

	always_comb begin
		sz_ext = {1'b0, in_rec.sz};
		match  = !in_rec.hit && (sz_ext <= RndFullW'(HI));
		// sizes here are above LO, so neither subtract wraps when matched
		off    = sz_ext - RndFullW'(LO) - RndFullW'(1);
		units  = ((sz_ext - RndFullW'(1)) >> SHIFT) + RndFullW'(1);
		rec_d  = in_rec;
		if (match) begin
			rec_d.hit = 1'b1;
			rec_d.cls = ClsW'(RndFullW'(BASE) + (off >> SHIFT));
			rec_d.rnd = units << SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_q <= rec_d;
		end
	end

	assign out_valid = valid_q;
	assign out_rec   = rec_q;

endmodule

FILE: rtl/core/ascm_div_cell.sv
// ----------------------------------------------------------------------------
// ascm_div_cell
// One restoring-division step: resolves quotient bit BIT of the batch
// budget divided by the rounded size.
// ----------------------------------------------------------------------------
module ascm_div_cell import ascm_pkg::*; #(
	parameter int unsigned BIT = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  div_rec_t in_rec,
	output logic     out_valid,
	output div_rec_t out_rec
);

	logic              valid_q;
	div_rec_t          rec_q;
	div_rec_t          rec_d;
	logic [TrialW-1:0] trial;
	logic              fits;

	always_comb begin
		trial = TrialW'(in_rec.rnd) << BIT;
		fits  = TrialW'(in_rec.rem) >= trial;
		rec_d = in_rec;
		if (fits) begin
			rec_d.rem      = in_rec.rem - trial[EffW-1:0];
			rec_d.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_q <= rec_d;
		end
	end

	assign out_valid = valid_q;
	assign out_rec   = rec_q;

endmodule

FILE: rtl/core/alloc_size_class_mapper.sv
// ----------------------------------------------------------------------------
// alloc_size_class_mapper
// Pipeline: 5 range cells, 10 divider cells and 1 output register. Throughput:
// one beat per cycle unless a stalled response holds the row.
// The whole row advances together; a stalled response holds every cell.
// Reset clears all valid bits; no response is pending after reset.
// Size class lookup: class index, rounded size and central refill batch.
// ----------------------------------------------------------------------------
module alloc_size_class_mapper import ascm_pkg::*; #(
	parameter int unsigned MAX_REQUEST_BYTES = DefMaxRequestBytes
) (
	input logic         clk,
	input logic         arst_n,
	ascm_req_if.sink    req,
	ascm_rsp_if.source  rsp
);

	logic                en;
	logic [EffW-1:0]     sz_eff;
	logic                cls_v [NumRanges+1];
	class_rec_t          cls_r [NumRanges+1];
	logic                div_v [QuoW+1];
	div_rec_t            div_r [QuoW+1];
	div_rec_t            last;
	logic [BatchW-1:0]   batch_d;

	logic                valid_q;
	logic [ClsW-1:0]     cls_q;
	logic [RndW-1:0]     rnd_q;
	logic [BatchW-1:0]   batch_q;
	logic                too_large_q;

	assign en        = !valid_q || rsp.ready;
	assign req.ready = en;

	// entry: size with probe bit on top, zero treated as one byte
	always_comb begin
		sz_eff             = {req.oversize_probe, req.request_size};
		cls_v[0]           = req.valid;
		cls_r[0].sz        = (sz_eff == '0) ? EffW'(1) : sz_eff;
		cls_r[0].hit       = 1'b0;
		cls_r[0].cls       = '0;
		cls_r[0].rnd       = '0;
		cls_r[0].too_large = MaxW'(sz_eff) > MaxW'(MAX_REQUEST_BYTES);
	end

	for (genvar g = 0; g < NumRanges; g++) begin : g_range
		ascm_class_cell #(
			.BASE  (range_base(g)),
			.LO    (range_lo(g)),
			.SHIFT (range_shift(g)),
			.HI    (range_hi(g))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cls_v[g]),
			.in_rec    (cls_r[g]),
			.out_valid (cls_v[g+1]),
			.out_rec   (cls_r[g+1])
		);
	end

	// small rounded sizes saturate at BatchMax; the rest fit the quotient width
	always_comb begin
		div_v[0]           = cls_v[NumRanges];
		div_r[0].cls       = cls_r[NumRanges].cls;
		div_r[0].rnd       = cls_r[NumRanges].rnd;
		div_r[0].too_large = cls_r[NumRanges].too_large;
		div_r[0].sat       = cls_r[NumRanges].rnd <= RndFullW'(SatRnd);
		div_r[0].rem       = EffW'(BatchBudget);
		div_r[0].quo       = '0;
	end

	for (genvar g = 0; g < QuoW; g++) begin : g_div
		ascm_div_cell #(
			.BIT (QuoW - 1 - g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_v[g]),
			.in_rec    (div_r[g]),
			.out_valid (div_v[g+1]),
			.out_rec   (div_r[g+1])
		);
	end

	always_comb begin
		last = div_r[QuoW];
		if (last.sat) begin
			batch_d = BatchW'(BatchMax);
		end else if (last.quo < QuoW'(BatchMin)) begin
			batch_d = BatchW'(BatchMin);
		end else begin
			batch_d = BatchW'(last.quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= div_v[QuoW];
		end
	end

	// oversize beats report only the flag
	always_ff @(posedge clk) begin
		if (en) begin
			too_large_q <= last.too_large;
			cls_q       <= last.too_large ? '0 : last.cls;
			rnd_q       <= last.too_large ? '0 : last.rnd[RndW-1:0];
			batch_q     <= last.too_large ? '0 : batch_d;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.class_index  = cls_q;
	assign rsp.rounded_size = rnd_q;
	assign rsp.batch_count  = batch_q;
	assign rsp.too_large    = too_large_q;

endmodule

FILE: tb/alloc_size_class_mapper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alloc_size_class_mapper testbench
// Drives size lookups over the request channel and scores every response beat
// against a predicted class index, rounded size, batch count and oversize
// flag. Both channels idle at random; one stretch runs at full rate.
// ----------------------------------------------------------------------------
module alloc_size_class_mapper_tb import ascm_pkg::*; ();

	localparam int unsigned LimitBytes  = DefMaxRequestBytes;
	localparam int unsigned PipeLatency = 16;
	localparam int unsigned NumRandom   = 600;

	typedef struct packed {
		logic [ClsW-1:0]   cls;
		logic [RndW-1:0]   rnd;
		logic [BatchW-1:0] batch;
		logic              too_large;
	} size_class_t;

	class size_class_scoreboard;
		size_class_t pending_q[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function size_class_t lookup_class(logic [SizeW-1:0] size, logic probe);
			size_class_t res;
			int unsigned eff, first, lo, sh, rnd, batch;
			res = '0;
			eff = 32'({probe, size});
			if (eff > LimitBytes) begin
				res.too_large = 1'b1;
				return res;
			end
			if (eff == 0)
				eff = 1;  // zero-byte request behaves as one byte
			if (eff <= 128) begin
				first = 0;   lo = 0;         sh = 3;
			end else if (eff <= 1024) begin
				first = 16;  lo = 128;       sh = 4;
			end else if (eff <= 8 * 1024) begin
				first = 72;  lo = 1024;      sh = 7;
			end else if (eff <= 64 * 1024) begin
				first = 128; lo = 8 * 1024;  sh = 10;
			end else begin
				first = 184; lo = 64 * 1024; sh = 13;
			end
			rnd = (((eff - 1) >> sh) + 1) << sh;
			batch = BatchBudget / rnd;
			if (batch < BatchMin)
				batch = BatchMin;
			else if (batch > BatchMax)
				batch = BatchMax;
			res.cls   = ClsW'(first + ((eff - lo - 1) >> sh));
			res.rnd   = RndW'(rnd);
			res.batch = BatchW'(batch);
			return res;
		endfunction

		function void note_request(logic [SizeW-1:0] size, logic probe);
			pending_q.insert(pending_q.size(), lookup_class(size, probe));
		endfunction

		function void check_result(logic [ClsW-1:0] cls, logic [RndW-1:0] rnd,
				logic [BatchW-1:0] batch, logic too_large);
			size_class_t want;
			if (pending_q.size() == 0) begin
				$error("response beat with no request outstanding: class_index %0d", cls);
				mismatches++;
				return;
			end
			want = pending_q.pop_front();
			if (cls !== want.cls) begin
				$error("class_index: expected %0d, got %0d", want.cls, cls);
				mismatches++;
			end
			if (rnd !== want.rnd) begin
				$error("rounded_size: expected %0d, got %0d", want.rnd, rnd);
				mismatches++;
			end
			if (batch !== want.batch) begin
				$error("batch_count: expected %0d, got %0d", want.batch, batch);
				mismatches++;
			end
			if (too_large !== want.too_large) begin
				$error("too_large: expected %0b, got %0b", want.too_large, too_large);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;

	ascm_req_if req ();
	ascm_rsp_if rsp ();

	size_class_scoreboard sb;

	alloc_size_class_mapper #(.MAX_REQUEST_BYTES(LimitBytes)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400us;
		$display("FAILED: results differ");
		$finish;
	end

	// values read here are the pre-edge ones; driver updates land in the NBA region
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			sb.note_request(req.request_size, req.oversize_probe);
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.class_index, rsp.rounded_size, rsp.batch_count,
				rsp.too_large);
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= quiet || ($urandom_range(99) >= 30);
		end
	end

	// eff carries the probe in bit 18; leaves valid high on return
	task automatic send_size(input int unsigned eff);
		if (!quiet) begin
			while ($urandom_range(99) < 30) begin
				req.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req.valid          <= 1'b1;
		req.request_size   <= eff[SizeW-1:0];
		req.oversize_probe <= eff[SizeW];
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	function automatic int unsigned pick_size();
		int unsigned range_lo_b[5] = '{1, 129, 1025, 8193, 65537};
		int unsigned range_hi_b[5] = '{128, 1024, 8192, 65536, 262144};
		int unsigned edges[8] = '{128, 1024, 8192, 65536, 262144, 496, 504, 131072};
		int unsigned roll, r;
		roll = $urandom_range(99);
		if (roll < 60) begin
			r = $urandom_range(4);
			return $urandom_range(range_hi_b[r], range_lo_b[r]);
		end else if (roll < 75) begin
			return edges[$urandom_range(7)] + $urandom_range(2) - 1;
		end else if (roll < 90) begin
			return $urandom_range((1 << SizeW) - 1);
		end
		return $urandom_range((1 << EffW) - 1);
	endfunction

	initial begin
		int unsigned directed_sizes[] = '{0, 1, 8, 9, 128, 129, 1024, 1025, 8192, 8193,
			65536, 65537, 496, 497, 504, 512, 131072, 131073, 262143, 262144,
			262145, 524287, 174762};
		req.valid          <= 1'b0;
		req.request_size   <= '0;
		req.oversize_probe <= 1'b0;
		arst_n             <= 1'b0;
		quiet = 1'b0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_sizes[i])
			send_size(directed_sizes[i]);

		// hold off until the pipe has drained completely
		req.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);

		for (int n = 0; n < NumRandom; n++) begin
			quiet = (n >= 250 && n < 400);
			send_size(pick_size());
		end
		quiet = 1'b0;
		req.valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (2 * PipeLatency) @(posedge clk);

		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/ascm_pkg.sv
rtl/core/ascm_if.sv
rtl/core/ascm_class_cell.sv
rtl/core/ascm_div_cell.sv
rtl/core/alloc_size_class_mapper.sv
tb/alloc_size_class_mapper_tb.sv
